>>> hdl/deq_pkg.sv
// shared types and constants for the double-ended queue
package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;
    localparam int OUT_W   = 104;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        RD_POP   = 2'd0,
        RD_FRONT = 2'd1,
        RD_REAR  = 2'd2
    } rd_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_EXEC  = 3'd1,
        ST_FRONT = 3'd2,
        ST_REAR  = 3'd3,
        ST_LAST  = 3'd4,
        ST_OUT   = 3'd5
    } state_t;

    typedef struct packed {
        logic    load;
        logic    exec;
        logic    cap_pop;
        logic    cap_front;
        logic    cap_rear;
        rd_sel_t rd_sel;
    } deq_cmd_t;

endpackage

>>> hdl/deq_ram.sv
// generic single-write, single-read ram with registered read data
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/deq_ctrl.sv
// sequencing state machine for the double-ended queue
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output deq_pkg::deq_cmd_t cmd
);

    import deq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.load      = 1'b0;
        cmd.exec      = 1'b0;
        cmd.cap_pop   = 1'b0;
        cmd.cap_front = 1'b0;
        cmd.cap_rear  = 1'b0;
        cmd.rd_sel    = RD_POP;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                cmd.rd_sel = RD_POP;
                state_next = ST_FRONT;
            end
            ST_FRONT:
            begin
                cmd.cap_pop = 1'b1;
                cmd.rd_sel  = RD_FRONT;
                state_next  = ST_REAR;
            end
            ST_REAR:
            begin
                cmd.cap_front = 1'b1;
                cmd.rd_sel    = RD_REAR;
                state_next    = ST_LAST;
            end
            ST_LAST:
            begin
                cmd.cap_rear = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/deq_dpath.sv
// pointers, count, store and result registers of the double-ended queue
module deq_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  deq_pkg::deq_cmd_t                    cmd,
    input  deq_pkg::op_t                         op_in,
    input  logic signed [deq_pkg::WORD_W-1:0]    data_in,
    output logic signed [deq_pkg::WORD_W-1:0]    data_out,
    output deq_pkg::err_t                        error,
    output logic signed [deq_pkg::WORD_W-1:0]    front_word,
    output logic signed [deq_pkg::WORD_W-1:0]    rear_word,
    output logic [deq_pkg::COUNT_W-1:0]          count,
    output logic                                 is_empty
);

    import deq_pkg::*;

    op_t                op_reg;
    logic [WORD_W-1:0]  din_reg;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    err_t               err_reg, err_next;
    logic               pop_ok_reg, pop_ok_next;
    logic [WORD_W-1:0]  dout_reg;
    logic [WORD_W-1:0]  front_reg;
    logic [WORD_W-1:0]  rear_reg;

    logic               we;
    logic [PTR_W-1:0]   waddr;
    logic [PTR_W-1:0]   raddr;
    logic [WORD_W-1:0]  rd_data;
    logic [PTR_W-1:0]   head_dec;
    logic [PTR_W-1:0]   head_inc;
    logic [PTR_W-1:0]   tail_dec;
    logic [PTR_W-1:0]   tail_inc;
    logic               full;
    logic               empty;

    assign head_dec = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? PTR_W'(DEPTH - 1) : tail_reg - 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);

    // request execution: pointer and count update, store write
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        pop_ok_next = pop_ok_reg;
        we          = 1'b0;
        waddr       = tail_reg;
        if (cmd.exec)
        begin
            err_next    = ERR_OK;
            pop_ok_next = 1'b0;
            case (op_reg)
                OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        err_next = ERR_FULL;
                    end
                    else
                    begin
                        head_next = head_dec;
                        waddr     = head_dec;
                        we        = 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
                OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        err_next = ERR_FULL;
                    end
                    else
                    begin
                        waddr     = tail_reg;
                        we        = 1'b1;
                        tail_next = tail_inc;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        err_next = ERR_EMPTY;
                    end
                    else
                    begin
                        pop_ok_next = 1'b1;
                        head_next   = head_inc;
                        cnt_next    = cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    if (empty)
                    begin
                        err_next = ERR_EMPTY;
                    end
                    else
                    begin
                        pop_ok_next = 1'b1;
                        tail_next   = tail_dec;
                        cnt_next    = cnt_reg - 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_POP:   raddr = (op_reg == OP_POP_FRONT) ? head_reg : tail_dec;
            RD_FRONT: raddr = head_reg;
            RD_REAR:  raddr = tail_dec;
            default:  raddr = head_reg;
        endcase
    end

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (din_reg),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg    <= err_next;
        pop_ok_reg <= pop_ok_next;
        if (cmd.load)
        begin
            op_reg  <= op_in;
            din_reg <= data_in;
        end
        if (cmd.cap_pop)
        begin
            dout_reg <= pop_ok_reg ? rd_data : '0;
        end
        if (cmd.cap_front)
        begin
            front_reg <= empty ? '0 : rd_data;
        end
        if (cmd.cap_rear)
        begin
            rear_reg <= empty ? '0 : rd_data;
        end
    end

    assign data_out   = dout_reg;
    assign error      = err_reg;
    assign front_word = front_reg;
    assign rear_word  = rear_reg;
    assign count      = COUNT_W'(cnt_reg);
    assign is_empty   = empty;

endmodule

>>> hdl/double_ended_queue.sv
// top level of the double-ended queue
// A double-ended queue of 16 signed 32-bit words held in a ring store. Each
// request pushes at the front or rear or pops from the front or rear, and
// gives one result with the popped word, an error code and the front word,
// rear word, count and empty flag after the request. The controller steps
// through EXEC, FRONT, REAR and LAST before the result is valid: the store
// has one read port, so the popped word, the new front and the new rear are
// read in turn. A new request is accepted in the cycle after the result is
// taken, not before. No clearing pass follows reset.
module double_ended_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [deq_pkg::WORD_W-1:0]  s_axis_tdata,   // data_in
    input  logic [1:0]                  s_axis_tuser,   // op
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [deq_pkg::OUT_W-1:0]   m_axis_tdata    // data_out, error, front_word,
                                                        // rear_word, count, is_empty
);

    import deq_pkg::*;

    deq_cmd_t                  cmd;
    logic signed [WORD_W-1:0]  data_out;
    err_t                      error;
    logic signed [WORD_W-1:0]  front_word;
    logic signed [WORD_W-1:0]  rear_word;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    deq_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .op_in      (op_t'(s_axis_tuser)),
        .data_in    (s_axis_tdata),
        .data_out   (data_out),
        .error      (error),
        .front_word (front_word),
        .rear_word  (rear_word),
        .count      (count),
        .is_empty   (is_empty)
    );

    assign m_axis_tdata = {is_empty, count, rear_word, front_word, error, data_out};

endmodule
